/* hdl/rsnp_pkg.sv */
package rsnp_pkg;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLowOff = 8'h57;
  localparam logic [7:0] ChUpOff  = 8'h37;
  localparam logic [7:0] ChUpO    = 8'h4f;
  localparam logic [7:0] ChLowO   = 8'h6f;
  localparam logic [7:0] ChUpQ    = 8'h51;
  localparam logic [7:0] ChLowQ   = 8'h71;
  localparam logic [7:0] ChUpH    = 8'h48;
  localparam logic [7:0] ChLowH   = 8'h68;
  localparam logic [7:0] ChUpD    = 8'h44;
  localparam logic [7:0] ChLowD   = 8'h64;

  localparam logic [1:0] RadixOct = 2'd0;
  localparam logic [1:0] RadixDec = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  typedef struct packed {
    logic        active;
    logic [31:0] acc_oct;
    logic [31:0] acc_dec;
    logic [31:0] acc_dec_prev;
    logic [31:0] acc_hex;
    logic        bad_oct;
    logic        bad_dec;
    logic        bad_dec_prev;
    logic        last_was_d;
  } lit_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic        error;
    logic [1:0]  radix;
    logic        suffix;
  } result_t;

  // {is_hex, digit}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] diff;
    logic       ok;
    diff = 8'h00;
    ok   = 1'b0;
    if (c >= ChZero && c <= ChNine) begin
      diff = c - ChZero;
      ok   = 1'b1;
    end else if (c >= ChLowA && c <= ChLowF) begin
      diff = c - ChLowOff;
      ok   = 1'b1;
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff = c - ChUpOff;
      ok   = 1'b1;
    end
    return {ok, diff[3:0]};
  endfunction

endpackage

/* hdl/radix_suffix_number_parser_unit.sv */
// Number literal parser, one ASCII character per input beat.
// Input channel: in_valid_i / in_stall_o with ch_i and start_req_i. A beat
// with start_req_i high drops any unfinished literal and opens a new one, or
// yields an error result if its character is not hex. The first non-hex
// character closes the literal: O/Q/o/q selects octal, H/h selects hex (both
// consumed); anything else selects decimal, dropping an optional trailing D/d.
// Output channel: out_valid_o / out_stall_i with value_o, error_o, radix_o
// and suffix_consumed_o. Beats that only add a digit produce no result.
// The closing beat is held in the input register once accepted; its result is
// then written to the result register, from which it is presented.
// Throughput: one beat per cycle while out_stall_i holds no pending result, set
// by the combinational step logic between the two registers.
// Stall: while out_stall_i holds a pending result, the input register keeps
// its beat and in_stall_o rises; with the result register free, it drains.
// Reset clears the parser state and both valid flags; no literal is open.
module radix_suffix_number_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic        error_o,
  output logic [1:0]  radix_o,
  output logic        suffix_consumed_o
);

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           ch_q;
  logic                 start_q;
  logic                 out_valid_q, out_valid_d;
  rsnp_pkg::result_t    res_q;
  rsnp_pkg::lit_state_t st_q, st_d;
  rsnp_pkg::result_t    res_d;
  logic                 out_ready;
  logic                 fire;
  logic                 in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  rsnp_step u_step (
    .st_i    (st_q),
    .ch_i    (ch_q),
    .start_i (start_q),
    .st_o    (st_d),
    .res_o   (res_d)
  );

  assign in_valid_d  = in_take || (in_valid_q && !fire);
  assign out_valid_d = out_ready ? (fire && res_d.valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q    <= ch_i;
      start_q <= start_req_i;
    end
    if (fire && res_d.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign value_o           = res_q.value;
  assign error_o           = res_q.error;
  assign radix_o           = res_q.radix;
  assign suffix_consumed_o = res_q.suffix;

endmodule

/* hdl/rsnp_step.sv */
module rsnp_step (
  input  rsnp_pkg::lit_state_t st_i,
  input  logic [7:0]           ch_i,
  input  logic                 start_i,
  output rsnp_pkg::lit_state_t st_o,
  output rsnp_pkg::result_t    res_o
);

  logic [4:0]           hv;
  logic                 is_hex;
  logic [31:0]          dig;
  rsnp_pkg::lit_state_t base;
  rsnp_pkg::lit_state_t took;
  logic                 is_oct_suf;
  logic                 is_hex_suf;

  assign hv     = rsnp_pkg::hex_value(ch_i);
  assign is_hex = hv[4];
  assign dig    = {28'd0, hv[3:0]};

  always_comb begin
    base = st_i;
    if (start_i) begin
      base = '0;
    end
    took              = base;
    took.active       = 1'b1;
    took.acc_dec_prev = base.acc_dec;
    took.bad_dec_prev = base.bad_dec;
    took.bad_oct      = base.bad_oct | (ch_i > rsnp_pkg::ChSeven);
    took.bad_dec      = base.bad_dec | (ch_i > rsnp_pkg::ChNine);
    took.acc_oct      = {base.acc_oct[28:0], 3'd0} + dig;
    took.acc_dec      = {base.acc_dec[28:0], 3'd0} + {base.acc_dec[30:0], 1'b0} + dig;
    took.acc_hex      = {base.acc_hex[27:0], 4'd0} + dig;
    took.last_was_d   = (ch_i == rsnp_pkg::ChUpD) || (ch_i == rsnp_pkg::ChLowD);
  end

  assign is_oct_suf = (ch_i == rsnp_pkg::ChUpO) || (ch_i == rsnp_pkg::ChLowO) ||
                      (ch_i == rsnp_pkg::ChUpQ) || (ch_i == rsnp_pkg::ChLowQ);
  assign is_hex_suf = (ch_i == rsnp_pkg::ChUpH) || (ch_i == rsnp_pkg::ChLowH);

  always_comb begin
    st_o         = st_i;
    res_o        = '0;
    res_o.radix  = rsnp_pkg::RadixDec;
    if (start_i) begin
      if (is_hex) begin
        st_o = took;
      end else begin
        st_o        = '0;
        res_o.valid = 1'b1;
        res_o.error = 1'b1;
      end
    end else if (st_i.active) begin
      if (is_hex) begin
        st_o = took;
      end else begin
        st_o.active = 1'b0;
        res_o.valid = 1'b1;
        if (is_oct_suf) begin
          res_o.radix  = rsnp_pkg::RadixOct;
          res_o.suffix = 1'b1;
          res_o.error  = st_i.bad_oct;
          res_o.value  = st_i.acc_oct;
        end else if (is_hex_suf) begin
          res_o.radix  = rsnp_pkg::RadixHex;
          res_o.suffix = 1'b1;
          res_o.value  = st_i.acc_hex;
        end else if (st_i.last_was_d) begin
          res_o.error = st_i.bad_dec_prev;
          res_o.value = st_i.acc_dec_prev;
        end else begin
          res_o.error = st_i.bad_dec;
          res_o.value = st_i.acc_dec;
        end
        if (res_o.error) begin
          res_o.value = '0;
        end
      end
    end
  end

endmodule

/* hdl/rsnp_checker.sv */
module rsnp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o,
  input logic        error_o,
  input logic [1:0]  radix_o,
  input logic        suffix_consumed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(error_o))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> value_o == 32'd0 && radix_o != rsnp_pkg::RadixHex)
    else $error("error result with nonzero value or hex radix");

  a_suffix_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> suffix_consumed_o == (radix_o != rsnp_pkg::RadixDec))
    else $error("suffix flag disagrees with radix");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result slot");

endmodule

bind radix_suffix_number_parser_unit rsnp_checker u_rsnp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .value_o           (value_o),
  .error_o           (error_o),
  .radix_o           (radix_o),
  .suffix_consumed_o (suffix_consumed_o)
);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int ItemTarget = 1300;
  localparam int QuietTail  = 150;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
    logic [1:0]  radix;
    logic        suffix;
  } literal_res_t;

  class numlit_scoreboard;
    bit          open_lit;
    logic [31:0] oct_acc, dec_acc, dec_acc_prev, hex_acc;
    bit          oct_bad, dec_bad, dec_bad_prev, ends_in_d;
    literal_res_t parsed_q[$];
    int          errors;

    static function bit hex_digit(logic [7:0] c, output logic [3:0] d);
      logic [7:0] t;
      t = 8'h00;
      hex_digit = 1'b1;
      if (c >= rsnp_pkg::ChZero && c <= rsnp_pkg::ChNine) begin
        t = c - rsnp_pkg::ChZero;
      end else if (c >= rsnp_pkg::ChLowA && c <= rsnp_pkg::ChLowF) begin
        t = c - rsnp_pkg::ChLowA + 8'd10;
      end else if (c >= rsnp_pkg::ChUpA && c <= rsnp_pkg::ChUpF) begin
        t = c - rsnp_pkg::ChUpA + 8'd10;
      end else begin
        hex_digit = 1'b0;
      end
      d = t[3:0];
    endfunction

    function void restart();
      open_lit = 1'b0;
      oct_acc = '0;
      dec_acc = '0;
      dec_acc_prev = '0;
      hex_acc = '0;
      oct_bad = 1'b0;
      dec_bad = 1'b0;
      dec_bad_prev = 1'b0;
      ends_in_d = 1'b0;
    endfunction

    function new();
      restart();
      errors = 0;
    endfunction

    function void push(logic [31:0] v, bit e, logic [1:0] r, bit s);
      literal_res_t res;
      res.value = e ? 32'd0 : v;
      res.error = e;
      res.radix = r;
      res.suffix = s;
      parsed_q.push_back(res);
    endfunction

    function void add_digit(logic [7:0] c, logic [3:0] d);
      dec_acc_prev = dec_acc;
      dec_bad_prev = dec_bad;
      if (c > rsnp_pkg::ChSeven) oct_bad = 1'b1;
      if (c > rsnp_pkg::ChNine) dec_bad = 1'b1;
      oct_acc = oct_acc * 32'd8 + 32'(d);
      dec_acc = dec_acc * 32'd10 + 32'(d);
      hex_acc = hex_acc * 32'd16 + 32'(d);
      ends_in_d = (c == rsnp_pkg::ChUpD || c == rsnp_pkg::ChLowD);
    endfunction

    // Returns 1 when the beat is not simply ignored.
    function bit note_beat(logic [7:0] c, logic s);
      logic [3:0] d;
      bit         is_hex;
      is_hex = hex_digit(c, d);
      if (s) begin
        restart();
        if (!is_hex) begin
          push(32'd0, 1'b1, rsnp_pkg::RadixDec, 1'b0);
        end else begin
          add_digit(c, d);
          open_lit = 1'b1;
        end
        return 1'b1;
      end
      if (!open_lit) return 1'b0;
      if (is_hex) begin
        add_digit(c, d);
        return 1'b1;
      end
      open_lit = 1'b0;
      if (c == rsnp_pkg::ChUpO || c == rsnp_pkg::ChLowO ||
          c == rsnp_pkg::ChUpQ || c == rsnp_pkg::ChLowQ)
        push(oct_acc, oct_bad, rsnp_pkg::RadixOct, 1'b1);
      else if (c == rsnp_pkg::ChUpH || c == rsnp_pkg::ChLowH)
        push(hex_acc, 1'b0, rsnp_pkg::RadixHex, 1'b1);
      else if (ends_in_d)
        push(dec_acc_prev, dec_bad_prev, rsnp_pkg::RadixDec, 1'b0);
      else
        push(dec_acc, dec_bad, rsnp_pkg::RadixDec, 1'b0);
      return 1'b1;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [31:0] v, logic e, logic [1:0] r, logic s);
      literal_res_t want;
      if (parsed_q.size() == 0) begin
        flag($sformatf("result with none pending: value=%h error=%b radix=%0d suffix=%b",
                       v, e, r, s));
        return;
      end
      want = parsed_q.pop_front();
      if (want.value !== v || want.error !== e || want.radix !== r || want.suffix !== s)
        flag($sformatf({"mismatch: exp value=%h error=%b radix=%0d suffix=%b, ",
                        "got value=%h error=%b radix=%0d suffix=%b"},
                       want.value, want.error, want.radix, want.suffix, v, e, r, s));
    endfunction

    function int pending();
      return parsed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  ch = 8'h00;
  logic        start_req = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] res_value;
  logic        res_error;
  logic [1:0]  res_radix;
  logic        res_suffix;

  numlit_scoreboard sb = new();
  int counted = 0;
  bit quiet = 1'b0;
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;

  radix_suffix_number_parser_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .ch_i              (ch),
    .start_req_i       (start_req),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .value_o           (res_value),
    .error_o           (res_error),
    .radix_o           (res_radix),
    .suffix_consumed_o (res_suffix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_suffix(logic [7:0] c);
    return c == rsnp_pkg::ChUpO || c == rsnp_pkg::ChLowO || c == rsnp_pkg::ChUpQ ||
           c == rsnp_pkg::ChLowQ || c == rsnp_pkg::ChUpH || c == rsnp_pkg::ChLowH;
  endfunction

  function automatic logic [7:0] any_hex_digit();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return rsnp_pkg::ChZero + 8'(k);
    if (k < 16) return rsnp_pkg::ChLowA + 8'(k - 10);
    return rsnp_pkg::ChUpA + 8'(k - 16);
  endfunction

  function automatic logic [7:0] any_non_hex();
    logic [7:0] c;
    logic [3:0] d;
    do c = 8'($urandom_range(0, 255));
    while (numlit_scoreboard::hex_digit(c, d));
    return c;
  endfunction

  function automatic logic [7:0] plain_end();
    logic [7:0] c;
    do c = any_non_hex();
    while (is_suffix(c));
    return c;
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic s);
    if (gap_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    start_req <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_beat(c, s)) counted++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_literal();
    int         kind;
    int         len;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
    if (kind == 9) begin
      send_beat(any_non_hex(), 1'b1);
      repeat ($urandom_range(0, 2)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    for (int i = 0; i < len; i++) begin
      if (kind <= 1)
        c = ($urandom_range(0, 19) == 0) ? any_hex_digit() :
            rsnp_pkg::ChZero + 8'($urandom_range(0, 7));
      else if (kind >= 4 && kind <= 6)
        c = ($urandom_range(0, 19) == 0) ? any_hex_digit() :
            rsnp_pkg::ChZero + 8'($urandom_range(0, 9));
      else
        c = any_hex_digit();
      send_beat(c, i == 0);
    end
    case (kind)
      0, 1: begin
        case ($urandom_range(0, 3))
          0: send_beat(rsnp_pkg::ChUpO, 1'b0);
          1: send_beat(rsnp_pkg::ChLowO, 1'b0);
          2: send_beat(rsnp_pkg::ChUpQ, 1'b0);
          default: send_beat(rsnp_pkg::ChLowQ, 1'b0);
        endcase
      end
      2, 3: send_beat($urandom_range(0, 1) ? rsnp_pkg::ChUpH : rsnp_pkg::ChLowH, 1'b0);
      4, 5, 6: begin
        if ($urandom_range(0, 3) == 0)
          send_beat($urandom_range(0, 1) ? rsnp_pkg::ChUpD : rsnp_pkg::ChLowD, 1'b0);
        send_beat(plain_end(), 1'b0);
      end
      7: send_beat(any_non_hex(), 1'b0);
      default: ;
    endcase
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(res_value, res_error, res_radix, res_suffix);
      if (hold != 0 && !quiet) begin
        hold--;
        out_stall <= 1'b1;
      end else if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h5A, 1'b0);
    send_beat(rsnp_pkg::ChSeven, 1'b1);
    send_beat(rsnp_pkg::ChSeven, 1'b0);
    send_beat(rsnp_pkg::ChZero, 1'b0);
    send_beat(rsnp_pkg::ChLowQ, 1'b0);
    send_beat(rsnp_pkg::ChNine, 1'b1);
    send_beat(rsnp_pkg::ChUpO, 1'b0);
    send_beat(rsnp_pkg::ChUpF, 1'b1);
    send_beat(rsnp_pkg::ChLowF, 1'b0);
    send_beat(rsnp_pkg::ChLowA, 1'b0);
    send_beat(rsnp_pkg::ChLowH, 1'b0);
    send_beat(rsnp_pkg::ChNine, 1'b1);
    send_beat(8'h2C, 1'b0);
    send_beat(rsnp_pkg::ChNine, 1'b1);
    send_beat(rsnp_pkg::ChLowD, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(rsnp_pkg::ChUpD, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(rsnp_pkg::ChLowA, 1'b1);
    send_beat(rsnp_pkg::ChNine, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(rsnp_pkg::ChUpF, 1'b1);
    send_beat(rsnp_pkg::ChNine, 1'b0);
    send_beat(rsnp_pkg::ChZero, 1'b1);
    send_beat(rsnp_pkg::ChUpQ, 1'b0);
    drain_results();

    while (counted < ItemTarget) begin
      if (counted > ItemTarget - QuietTail) quiet = 1'b1;
      if ($urandom_range(0, 30) == 0) gap_on = !gap_on;
      if ($urandom_range(0, 30) == 0) stall_on = !stall_on;
      if ($urandom_range(0, 120) == 0) drain_results();
      send_literal();
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
